// ----- rtl/ffha_pkg.sv -----
package ffha_pkg;

    localparam int HEAP_MAX_BYTES = 4096;
    localparam int ADDR_W = 12;
    localparam int SIZE_W = 16;
    localparam int ENTRY_W = SIZE_W + 1;
    localparam int POS_W = 18;
    localparam int HEAP_W = 13;

    localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(6);
    localparam logic [POS_W-1:0] END_BYTES = POS_W'(4);
    localparam logic [HEAP_W-1:0] HEAP_MIN = HEAP_W'(16);
    localparam logic [HEAP_W-1:0] HEAP_RESET = HEAP_W'(HEAP_MAX_BYTES);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE = 1'b1;

    localparam logic [1:0] RES_DONE = 2'd0;
    localparam logic [1:0] RES_NO_MEM = 2'd1;
    localparam logic [1:0] RES_NOT_FOUND = 2'd2;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_RELAY,
        DP_START,
        DP_READ,
        DP_STEP,
        DP_ALLOC_HDR,
        DP_ALLOC_REM,
        DP_FREE_MARK
    } t_dp_op;

    typedef enum logic [2:0] {
        MG_NOP,
        MG_START,
        MG_READ_H,
        MG_READ_NX,
        MG_ABSORB,
        MG_WRITE,
        MG_ADVANCE
    } t_mg_op;

    typedef struct packed {
        t_dp_op op;
        t_mg_op mg;
    } t_cmd;

    typedef struct packed {
        logic h_ok;
        logic nx_ok;
        logic cur_free;
        logic cur_fits;
        logic cur_match;
        logic nx_free;
    } t_status;

endpackage

// ----- rtl/ffha_datapath.sv -----
module ffha_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ffha_pkg::t_cmd            i_cmd,
    input  logic [ffha_pkg::HEAP_W-1:0] i_heap_bytes,
    input  logic [11:0]               i_req_size,
    input  logic [11:0]               i_free_offset,
    output ffha_pkg::t_status         o_status,
    output logic [11:0]               o_data_offset
);

    logic [ffha_pkg::ENTRY_W-1:0] r_mem [ffha_pkg::HEAP_MAX_BYTES];
    logic [ffha_pkg::ENTRY_W-1:0] r_rd;
    logic [ffha_pkg::ADDR_W-1:0]  r_clr;
    logic                         r_clr_on;
    logic [ffha_pkg::POS_W-1:0]   r_h;
    logic [ffha_pkg::POS_W-1:0]   r_nx;
    logic [ffha_pkg::POS_W-1:0]   r_size;
    logic [ffha_pkg::POS_W-1:0]   r_end;

    logic                         we;
    logic [ffha_pkg::ADDR_W-1:0]  wa;
    logic [ffha_pkg::ENTRY_W-1:0] wd;
    logic [ffha_pkg::ADDR_W-1:0]  ra;
    logic [ffha_pkg::POS_W-1:0]   rd_size;
    logic [ffha_pkg::POS_W-1:0]   req;
    logic [ffha_pkg::POS_W-1:0]   rem;
    logic [ffha_pkg::POS_W-1:0]   sum_size;

    assign rd_size = ffha_pkg::POS_W'(r_rd[ffha_pkg::SIZE_W-1:0]);
    assign req = ffha_pkg::POS_W'(i_req_size);
    assign rem = r_h + ffha_pkg::HDR_BYTES + req;
    assign sum_size = r_size + rd_size + ffha_pkg::HDR_BYTES;

    always_comb begin
        o_status.h_ok = (r_h + ffha_pkg::HDR_BYTES <= r_end)
            && (r_h < ffha_pkg::POS_W'(ffha_pkg::HEAP_MAX_BYTES));
        o_status.nx_ok = (r_nx + ffha_pkg::HDR_BYTES <= r_end)
            && (r_nx < ffha_pkg::POS_W'(ffha_pkg::HEAP_MAX_BYTES));
        o_status.cur_free = !r_rd[ffha_pkg::SIZE_W];
        o_status.cur_fits = rd_size >= req + ffha_pkg::HDR_BYTES;
        o_status.cur_match = (r_h + ffha_pkg::HDR_BYTES)
            == ffha_pkg::POS_W'(i_free_offset);
        o_status.nx_free = !r_rd[ffha_pkg::SIZE_W];
    end

    assign o_data_offset = 12'(r_h + ffha_pkg::HDR_BYTES);

    always_comb begin
        we = 1'b0;
        wa = r_h[ffha_pkg::ADDR_W-1:0];
        wd = '0;
        ra = r_h[ffha_pkg::ADDR_W-1:0];
        if (r_clr_on) begin
            we = 1'b1;
            wa = r_clr;
            wd = (r_clr == '0) ? ffha_pkg::ENTRY_W'(ffha_pkg::POS_W'(i_heap_bytes) - 18'd10)
                : '0;
        end
        case (i_cmd.op)
            ffha_pkg::DP_ALLOC_HDR: begin
                we = 1'b1;
                wd = {1'b1, ffha_pkg::SIZE_W'(req)};
            end
            ffha_pkg::DP_ALLOC_REM: begin
                we = rem < ffha_pkg::POS_W'(ffha_pkg::HEAP_MAX_BYTES);
                wa = rem[ffha_pkg::ADDR_W-1:0];
                wd = {1'b0, ffha_pkg::SIZE_W'(r_size - req - ffha_pkg::HDR_BYTES)};
            end
            ffha_pkg::DP_FREE_MARK: begin
                we = 1'b1;
                wd = {1'b0, r_rd[ffha_pkg::SIZE_W-1:0]};
            end
            default: ;
        endcase
        case (i_cmd.mg)
            ffha_pkg::MG_READ_NX: ra = r_nx[ffha_pkg::ADDR_W-1:0];
            ffha_pkg::MG_WRITE: begin
                we = 1'b1;
                wd = {1'b0, ffha_pkg::SIZE_W'(r_size)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_on <= 1'b1;
            r_clr <= '0;
            r_h <= '0;
            r_nx <= '0;
            r_size <= '0;
            r_end <= ffha_pkg::POS_W'(ffha_pkg::HEAP_RESET) - ffha_pkg::END_BYTES;
        end else begin
            if (i_cmd.op == ffha_pkg::DP_RELAY) begin
                r_clr_on <= 1'b1;
                r_clr <= '0;
                r_end <= ffha_pkg::POS_W'(i_heap_bytes) - ffha_pkg::END_BYTES;
            end else if (r_clr_on) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == '1) begin
                    r_clr_on <= 1'b0;
                end
            end
            case (i_cmd.op)
                ffha_pkg::DP_START: r_h <= '0;
                ffha_pkg::DP_STEP: r_h <= r_h + ffha_pkg::HDR_BYTES + rd_size;
                ffha_pkg::DP_READ: r_size <= rd_size;
                default: ;
            endcase
            case (i_cmd.mg)
                ffha_pkg::MG_START: r_h <= '0;
                ffha_pkg::MG_READ_H: begin
                    r_size <= rd_size;
                    r_nx <= r_h + ffha_pkg::HDR_BYTES + rd_size;
                end
                ffha_pkg::MG_ABSORB: begin
                    r_size <= sum_size;
                    r_nx <= r_h + ffha_pkg::HDR_BYTES + sum_size;
                end
                ffha_pkg::MG_WRITE: r_h <= r_h + ffha_pkg::HDR_BYTES + r_size;
                ffha_pkg::MG_ADVANCE: r_h <= r_h + ffha_pkg::HDR_BYTES + r_size;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/ffha_ctrl.sv -----
module ffha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_busy_clear,
    input  logic              i_out_free,
    output logic              o_res_load,
    output logic [1:0]        o_res_code,
    output logic              o_res_offset_en,
    input  ffha_pkg::t_status i_status,
    output ffha_pkg::t_cmd    o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_WALK   = 11'b00000000010,
        S_EVAL   = 11'b00000000100,
        S_AREM   = 11'b00000001000,
        S_MFIRST = 11'b00000010000,
        S_MCHK   = 11'b00000100000,
        S_MRD    = 11'b00001000000,
        S_MEVAL  = 11'b00010000000,
        S_MNX    = 11'b00100000000,
        S_MNXEV  = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_func;

    assign o_in_ready = (r_state == S_IDLE) && !i_busy_clear && i_out_free && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_busy_clear;

    always_comb begin
        n_state = r_state;
        o_cmd = '{op: ffha_pkg::DP_NOP, mg: ffha_pkg::MG_NOP};
        o_res_load = 1'b0;
        o_res_code = ffha_pkg::RES_DONE;
        o_res_offset_en = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid && o_cfg_ready) begin
                    o_cmd.op = ffha_pkg::DP_RELAY;
                end else if (i_in_valid && o_in_ready) begin
                    o_cmd.op = ffha_pkg::DP_START;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!i_status.h_ok) begin
                    o_res_load = 1'b1;
                    o_res_code = (r_func == ffha_pkg::FUNC_ALLOC)
                        ? ffha_pkg::RES_NO_MEM : ffha_pkg::RES_NOT_FOUND;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_func == ffha_pkg::FUNC_ALLOC) begin
                    if (i_status.cur_free && i_status.cur_fits) begin
                        o_cmd.op = ffha_pkg::DP_READ;
                        n_state = S_AREM;
                    end else begin
                        o_cmd.op = ffha_pkg::DP_STEP;
                        n_state = S_WALK;
                    end
                end else if (i_status.cur_match) begin
                    o_cmd.op = ffha_pkg::DP_FREE_MARK;
                    n_state = S_MFIRST;
                end else begin
                    o_cmd.op = ffha_pkg::DP_STEP;
                    n_state = S_WALK;
                end
            end
            S_AREM: begin
                o_cmd.op = ffha_pkg::DP_ALLOC_HDR;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.op = ffha_pkg::DP_ALLOC_REM;
                o_res_load = 1'b1;
                o_res_offset_en = 1'b1;
                n_state = S_IDLE;
            end
            S_MFIRST: begin
                o_cmd.mg = ffha_pkg::MG_START;
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (!i_status.h_ok) begin
                    o_res_load = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                o_cmd.mg = ffha_pkg::MG_READ_H;
                n_state = S_MEVAL;
            end
            S_MEVAL: begin
                if (i_status.cur_free) begin
                    n_state = S_MNX;
                end else begin
                    o_cmd.mg = ffha_pkg::MG_ADVANCE;
                    n_state = S_MCHK;
                end
            end
            S_MNX: begin
                if (i_status.nx_ok) begin
                    o_cmd.mg = ffha_pkg::MG_READ_NX;
                    n_state = S_MNXEV;
                end else begin
                    o_cmd.mg = ffha_pkg::MG_WRITE;
                    n_state = S_MCHK;
                end
            end
            S_MNXEV: begin
                if (i_status.nx_free) begin
                    o_cmd.mg = ffha_pkg::MG_ABSORB;
                    n_state = S_MNX;
                end else begin
                    o_cmd.mg = ffha_pkg::MG_WRITE;
                    n_state = S_MCHK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func <= ffha_pkg::FUNC_ALLOC;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_func <= i_func;
            end
        end
    end

endmodule

// ----- rtl/first_fit_heap_allocator_core.sv -----
// first fit heap allocator core
// input channel: i_in_valid / o_in_ready with i_func (0 allocate, 1 free),
// i_req_size and i_free_offset; one result per item on o_out_valid /
// i_out_ready with o_result_code and o_data_offset
// configuration: i_cfg_valid / o_cfg_ready with i_cfg_data (heap bytes,
// clamped to 16..4096); a write relays the heap as one free block
// the header store is a 4096 entry ram with one write and one registered
// read port, shared by the walk, the merge pass and the clearing pass
// allocate: walk the headers from offset 0 to the first free block that
// fits, then write the taken header and the header of the remainder;
// free: walk to the block whose data offset matches and mark it free,
// then a merge pass over all headers absorbs the free neighbors that
// follow each free block into that block
// after reset and after every configuration transfer a clearing pass
// writes all 4096 entries, one a cycle; no item is taken meanwhile
// the result sits in an output register; a stalled receiver holds it and
// the next item is not taken until that result has been transferred
module first_fit_heap_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [11:0] i_req_size,
    input  logic [11:0] i_free_offset,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_code,
    output logic [11:0] o_data_offset,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);

    ffha_pkg::t_cmd    cmd;
    ffha_pkg::t_status status;
    logic [ffha_pkg::HEAP_W-1:0] r_heap_bytes;
    logic [ffha_pkg::HEAP_W-1:0] clamp;
    logic [11:0] r_req, r_foff, dp_off;
    logic        r_valid, r_clearing;
    logic [11:0] r_clr_cnt;
    logic        res_load, res_off_en;
    logic [1:0]  res_code;
    logic        in_xfer;

    assign in_xfer = i_in_valid && o_in_ready;
    assign clamp = (i_cfg_data < ffha_pkg::HEAP_MIN) ? ffha_pkg::HEAP_MIN
        : (i_cfg_data > ffha_pkg::HEAP_RESET) ? ffha_pkg::HEAP_RESET : i_cfg_data;

    ffha_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_busy_clear    (r_clearing),
        .i_out_free      (!r_valid),
        .o_res_load      (res_load),
        .o_res_code      (res_code),
        .o_res_offset_en (res_off_en),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    ffha_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_heap_bytes  (cmd.op == ffha_pkg::DP_RELAY ? clamp : r_heap_bytes),
        .i_req_size    (r_req),
        .i_free_offset (r_foff),
        .o_status      (status),
        .o_data_offset (dp_off)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_bytes <= ffha_pkg::HEAP_RESET;
            r_valid <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_cnt <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_heap_bytes <= clamp;
                r_clearing <= 1'b1;
                r_clr_cnt <= '0;
            end else if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (res_load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= i_req_size;
            r_foff <= i_free_offset;
        end
        if (res_load) begin
            o_result_code <= res_code;
            o_data_offset <= res_off_en ? dp_off : '0;
        end
    end

    assign o_out_valid = r_valid;

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_in_ready)
        else $error("item taken during clear");
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !o_in_ready)
        else $error("item taken with result pending");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> !r_valid)
        else $error("result overwritten");

endmodule

// ----- tb/sv/tb_first_fit_heap_allocator_core.sv -----
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator_core;

    localparam int CYCLE_LIMIT = 10_000_000;

    typedef struct {
        logic [1:0]  code;
        logic [11:0] offset;
    } t_alloc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_func = ffha_pkg::FUNC_ALLOC;
    logic [11:0] i_req_size = '0;
    logic [11:0] i_free_offset = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_result_code;
    logic [11:0] o_data_offset;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [12:0] i_cfg_data = '0;

    logic [ffha_pkg::ENTRY_W-1:0] heap_model [0:ffha_pkg::HEAP_MAX_BYTES-1];
    int                 heap_size;
    t_alloc_result      pending_results [$];
    int                 live_blocks [$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    bit                 no_idle = 1'b0;

    first_fit_heap_allocator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_req_size    (i_req_size),
        .i_free_offset (i_free_offset),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_code (o_result_code),
        .o_data_offset (o_data_offset),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_first_fit_heap_allocator_core: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);
    end

    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result code=%0d offset=%0d", o_result_code, o_data_offset);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_result_code !== exp_res.code) begin
                    $error("result_code expected %0d actual %0d", exp_res.code, o_result_code);
                    error_count++;
                end
                if (o_data_offset !== exp_res.offset) begin
                    $error("data_offset expected %0d actual %0d", exp_res.offset,
                           o_data_offset);
                    error_count++;
                end
            end
        end
    end

    function automatic bit hdr_fits(int h);
        return (h + 6 <= heap_size - 4) && (h < ffha_pkg::HEAP_MAX_BYTES);
    endfunction

    function automatic int next_header(int h);
        return h + 6 + int'(heap_model[h][ffha_pkg::SIZE_W-1:0]);
    endfunction

    function automatic void relay_model(int bytes);
        heap_size = bytes < 16 ? 16
            : (bytes > ffha_pkg::HEAP_MAX_BYTES ? ffha_pkg::HEAP_MAX_BYTES : bytes);
        for (int i = 0; i < ffha_pkg::HEAP_MAX_BYTES; i++) heap_model[i] = '0;
        heap_model[0] = {1'b0, 16'(heap_size - 10)};
        live_blocks.delete();
    endfunction

    function automatic void coalesce_model();
        int h;
        int sz;
        int nx;
        h = 0;
        while (hdr_fits(h)) begin
            if (!heap_model[h][ffha_pkg::SIZE_W]) begin
                sz = int'(heap_model[h][ffha_pkg::SIZE_W-1:0]);
                nx = h + 6 + sz;
                while (hdr_fits(nx) && !heap_model[nx][ffha_pkg::SIZE_W]) begin
                    sz += int'(heap_model[nx][ffha_pkg::SIZE_W-1:0]) + 6;
                    nx = h + 6 + sz;
                end
                heap_model[h] = {1'b0, 16'(sz)};
            end
            h = next_header(h);
        end
    endfunction

    function automatic t_alloc_result predict_heap_op(logic fn, int req, int foff);
        t_alloc_result r;
        int h;
        int sz;
        int rem;
        r.code = ffha_pkg::RES_DONE;
        r.offset = '0;
        h = 0;
        if (fn == ffha_pkg::FUNC_ALLOC) begin
            while (hdr_fits(h)) begin
                sz = int'(heap_model[h][ffha_pkg::SIZE_W-1:0]);
                if (!heap_model[h][ffha_pkg::SIZE_W] && sz >= req + 6) begin
                    rem = h + 6 + req;
                    heap_model[h] = {1'b1, 16'(req)};
                    if (rem < ffha_pkg::HEAP_MAX_BYTES)
                        heap_model[rem] = {1'b0, 16'(sz - req - 6)};
                    r.offset = 12'(h + 6);
                    live_blocks.push_back(h + 6);
                    return r;
                end
                h = next_header(h);
            end
            r.code = ffha_pkg::RES_NO_MEM;
            return r;
        end
        while (hdr_fits(h)) begin
            if (h + 6 == foff) begin
                heap_model[h][ffha_pkg::SIZE_W] = 1'b0;
                coalesce_model();
                foreach (live_blocks[i]) begin
                    if (live_blocks[i] == foff) begin
                        live_blocks.delete(i);
                        break;
                    end
                end
                return r;
            end
            h = next_header(h);
        end
        r.code = ffha_pkg::RES_NOT_FOUND;
        return r;
    endfunction

    task automatic send_request(logic fn, int req, int foff);
        if (!no_idle && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_req_size <= 12'(req);
        i_free_offset <= 12'(foff);
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_heap_op(fn, req & 12'hfff, foff & 12'hfff));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_heap_bytes(int bytes);
        drain_results();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= 13'(bytes);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        relay_model(bytes & 13'h1fff);
    endtask

    task automatic test_directed_alloc();
        send_request(ffha_pkg::FUNC_ALLOC, 0, 0);
        send_request(ffha_pkg::FUNC_ALLOC, 100, 12'hfff);
        send_request(ffha_pkg::FUNC_ALLOC, 4086, 0);
        send_request(ffha_pkg::FUNC_ALLOC, 12'hfff, 0);
        send_request(ffha_pkg::FUNC_ALLOC, 3900, 0);
        send_request(ffha_pkg::FUNC_ALLOC, 50, 0);
        drain_results();
    endtask

    task automatic test_directed_free();
        send_request(ffha_pkg::FUNC_FREE, 0, 6);
        send_request(ffha_pkg::FUNC_FREE, 0, 6);
        send_request(ffha_pkg::FUNC_FREE, 12'hfff, 7);
        send_request(ffha_pkg::FUNC_FREE, 0, 12'hfff);
        send_request(ffha_pkg::FUNC_FREE, 0, 12);
        send_request(ffha_pkg::FUNC_FREE, 0, 0);
        send_request(ffha_pkg::FUNC_ALLOC, 10, 0);
        send_request(ffha_pkg::FUNC_ALLOC, 10, 0);
        send_request(ffha_pkg::FUNC_ALLOC, 10, 0);
        send_request(ffha_pkg::FUNC_FREE, 0, 22);
        send_request(ffha_pkg::FUNC_FREE, 0, 6);
        send_request(ffha_pkg::FUNC_FREE, 0, 38);
        drain_results();
    endtask

    task automatic test_heap_extremes();
        write_heap_bytes(0);
        send_request(ffha_pkg::FUNC_ALLOC, 0, 0);
        send_request(ffha_pkg::FUNC_ALLOC, 0, 0);
        send_request(ffha_pkg::FUNC_FREE, 0, 6);
        write_heap_bytes(16);
        send_request(ffha_pkg::FUNC_ALLOC, 1, 0);
        write_heap_bytes(13'h1fff);
        send_request(ffha_pkg::FUNC_ALLOC, 4080, 0);
        send_request(ffha_pkg::FUNC_ALLOC, 0, 0);
        drain_results();
    endtask

    task automatic test_random_traffic(int count, int bytes);
        int pick;
        int sel;
        write_heap_bytes(bytes);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 48) begin
                if ($urandom_range(9) == 0)
                    send_request(ffha_pkg::FUNC_ALLOC, $urandom_range(0, 4095), $urandom);
                else
                    send_request(ffha_pkg::FUNC_ALLOC, $urandom_range(0, 80), $urandom);
            end else if (pick < 88 && live_blocks.size() != 0) begin
                sel = $urandom_range(0, live_blocks.size() - 1);
                send_request(ffha_pkg::FUNC_FREE, $urandom, live_blocks[sel]);
            end else begin
                send_request(ffha_pkg::FUNC_FREE, $urandom, $urandom_range(0, 4095));
            end
        end
        drain_results();
    endtask

    initial begin
        relay_model(ffha_pkg::HEAP_MAX_BYTES);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_alloc();
        test_directed_free();
        test_heap_extremes();
        test_random_traffic(100, 4096);
        no_idle = 1'b1;
        test_random_traffic(60, 600);
        no_idle = 1'b0;
        test_random_traffic(80, 200);
        test_random_traffic(80, $urandom_range(16, 4096));
        test_random_traffic(80, 1500);
        drain_results();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_first_fit_heap_allocator_core: clean");
        end else begin
            $display("tb_first_fit_heap_allocator_core: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ffha_pkg.sv
rtl/ffha_datapath.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator_core.sv
tb/sv/tb_first_fit_heap_allocator_core.sv
